// ===== rtl/core/sukrt_pkg.sv =====
// Shared constants, codes and structs of the sorted unique-key record table.
package sukrt_pkg;

    localparam int CAPACITY    = 16;
    localparam int NAME_BITS   = 64;
    localparam int MAX_RESULTS = 16;
    localparam int KEY_W       = 32;
    localparam int NAME_W      = 64;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int REC_W       = KEY_W + NAME_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_SEARCH    = 3'd2,
        OP_DUMP_ASC  = 3'd3,
        OP_DUMP_DESC = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_INS_SHIFT,
        S_INS_WR,
        S_DEL_SHIFT,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [REC_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [NAME_BITS-1:0]    name;
        logic                    last;
    } t_result;

endpackage

// ===== rtl/core/sukrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sukrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sukrt_ctrl.sv =====
// Sequencer of the record table: key scan with one shared comparator, shifts and dumps.
module sukrt_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sukrt_pkg::OP_W-1:0]       i_opcode,
    input  logic signed [sukrt_pkg::KEY_W-1:0] i_key,
    input  logic [sukrt_pkg::NAME_W-1:0]     i_record_name,
    input  logic [sukrt_pkg::REC_W-1:0]      i_rd_data,
    output logic                             o_busy,
    output sukrt_pkg::t_ram_req              o_ram,
    output sukrt_pkg::t_result               o_res
);

    sukrt_pkg::t_state r_state, n_state;
    sukrt_pkg::t_op    r_op, n_op;
    logic signed [sukrt_pkg::KEY_W-1:0]   r_key, n_key;
    logic [sukrt_pkg::NAME_BITS-1:0]      r_name, n_name;
    logic [sukrt_pkg::CNT_W-1:0]          r_count, n_count;
    logic [sukrt_pkg::CNT_W-1:0]          r_idx, n_idx;
    logic [sukrt_pkg::CNT_W-1:0]          r_pos, n_pos;
    logic [sukrt_pkg::CNT_W-1:0]          r_lim, n_lim;

    logic signed [sukrt_pkg::KEY_W-1:0]   rd_key;
    logic [sukrt_pkg::NAME_BITS-1:0]      rd_name;
    logic                                 key_lt, key_eq;
    logic [sukrt_pkg::CNT_W-1:0]          idx_inc, idx_dec, dump_addr, lim_calc;
    logic                                 scan_done, scan_eq;

    assign {rd_key, rd_name} = i_rd_data;

    // The one comparator shared by every step of the scan.
    assign key_lt = rd_key < r_key;
    assign key_eq = rd_key == r_key;

    assign idx_inc   = r_idx + sukrt_pkg::CNT_W'(1);
    assign idx_dec   = r_idx - sukrt_pkg::CNT_W'(1);
    assign dump_addr = (r_op == sukrt_pkg::OP_DUMP_ASC) ? r_idx
                                                        : (r_count - idx_inc);
    assign lim_calc  = (32'(r_count) > sukrt_pkg::MAX_RESULTS)
                     ? sukrt_pkg::CNT_W'(sukrt_pkg::MAX_RESULTS) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sukrt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op   <= n_op;
        r_key  <= n_key;
        r_name <= n_name;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_lim  <= n_lim;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_name  = r_name;
        n_count = r_count;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_lim   = r_lim;

        o_ram        = '0;
        o_res        = '0;
        o_res.status = sukrt_pkg::ST_OK;
        o_res.last   = 1'b1;
        scan_done    = 1'b0;
        scan_eq      = 1'b0;

        case (r_state)
            sukrt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op   = sukrt_pkg::t_op'(i_opcode);
                    n_key  = i_key;
                    n_name = sukrt_pkg::NAME_BITS'(i_record_name);
                    n_idx  = '0;
                    case (sukrt_pkg::t_op'(i_opcode))
                        sukrt_pkg::OP_INSERT: begin
                            n_state = sukrt_pkg::S_SCAN;
                        end
                        sukrt_pkg::OP_DELETE, sukrt_pkg::OP_SEARCH,
                        sukrt_pkg::OP_DUMP_ASC, sukrt_pkg::OP_DUMP_DESC: begin
                            if (r_count == '0) begin
                                o_res.valid  = 1'b1;
                                o_res.status = sukrt_pkg::ST_EMPTY;
                            end else if (i_opcode == sukrt_pkg::OP_DELETE ||
                                         i_opcode == sukrt_pkg::OP_SEARCH) begin
                                n_state = sukrt_pkg::S_SCAN;
                            end else begin
                                n_lim   = lim_calc;
                                n_state = sukrt_pkg::S_DUMP_RD;
                            end
                        end
                        default: begin
                            n_state = sukrt_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sukrt_pkg::S_SCAN: begin
                if (r_idx < r_count) begin
                    o_ram.raddr = r_idx[sukrt_pkg::IDX_W-1:0];
                    n_state     = sukrt_pkg::S_CMP;
                end else begin
                    scan_done = 1'b1;
                end
            end
            sukrt_pkg::S_CMP: begin
                if (key_lt) begin
                    n_idx   = idx_inc;
                    n_state = sukrt_pkg::S_SCAN;
                end else begin
                    scan_done = 1'b1;
                    scan_eq   = key_eq;
                end
            end
            sukrt_pkg::S_INS_SHIFT: begin
                if (r_idx > r_pos) begin
                    o_ram.raddr = idx_dec[sukrt_pkg::IDX_W-1:0];
                    n_state     = sukrt_pkg::S_INS_WR;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos[sukrt_pkg::IDX_W-1:0];
                    o_ram.wdata = {r_key, r_name};
                    n_count     = r_count + sukrt_pkg::CNT_W'(1);
                    o_res.valid = 1'b1;
                    n_state     = sukrt_pkg::S_IDLE;
                end
            end
            sukrt_pkg::S_INS_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[sukrt_pkg::IDX_W-1:0];
                o_ram.wdata = i_rd_data;
                n_idx       = idx_dec;
                n_state     = sukrt_pkg::S_INS_SHIFT;
            end
            sukrt_pkg::S_DEL_SHIFT: begin
                if (idx_inc < r_count) begin
                    o_ram.raddr = idx_inc[sukrt_pkg::IDX_W-1:0];
                    n_state     = sukrt_pkg::S_DEL_WR;
                end else begin
                    n_count     = r_count - sukrt_pkg::CNT_W'(1);
                    o_res.valid = 1'b1;
                    n_state     = sukrt_pkg::S_IDLE;
                end
            end
            sukrt_pkg::S_DEL_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[sukrt_pkg::IDX_W-1:0];
                o_ram.wdata = i_rd_data;
                n_idx       = idx_inc;
                n_state     = sukrt_pkg::S_DEL_SHIFT;
            end
            sukrt_pkg::S_DUMP_RD: begin
                o_ram.raddr = dump_addr[sukrt_pkg::IDX_W-1:0];
                n_state     = sukrt_pkg::S_DUMP_OUT;
            end
            sukrt_pkg::S_DUMP_OUT: begin
                o_res.valid = 1'b1;
                o_res.key   = rd_key;
                o_res.name  = rd_name;
                o_res.last  = (idx_inc == r_lim);
                n_idx       = idx_inc;
                n_state     = (idx_inc == r_lim) ? sukrt_pkg::S_IDLE
                                                 : sukrt_pkg::S_DUMP_RD;
            end
            default: begin
                n_state = sukrt_pkg::S_IDLE;
            end
        endcase

        // The scan has found the first slot whose key is not below the search key, or has passed the last record.
        if (scan_done) begin
            n_state = sukrt_pkg::S_IDLE;
            case (r_op)
                sukrt_pkg::OP_INSERT: begin
                    if (scan_eq) begin
                        o_res.valid  = 1'b1;
                        o_res.status = sukrt_pkg::ST_DUP;
                    end else if (32'(r_count) == sukrt_pkg::CAPACITY) begin
                        o_res.valid  = 1'b1;
                        o_res.status = sukrt_pkg::ST_FULL;
                    end else begin
                        n_pos   = r_idx;
                        n_idx   = r_count;
                        n_state = sukrt_pkg::S_INS_SHIFT;
                    end
                end
                sukrt_pkg::OP_DELETE: begin
                    if (!scan_eq) begin
                        o_res.valid  = 1'b1;
                        o_res.status = sukrt_pkg::ST_NOTFOUND;
                    end else begin
                        n_state = sukrt_pkg::S_DEL_SHIFT;
                    end
                end
                default: begin
                    o_res.valid = 1'b1;
                    if (!scan_eq) begin
                        o_res.status = sukrt_pkg::ST_NOTFOUND;
                    end else begin
                        o_res.key  = rd_key;
                        o_res.name = rd_name;
                    end
                end
            endcase
        end
    end

    assign o_busy = (r_state != sukrt_pkg::S_IDLE);

endmodule

// ===== rtl/core/sorted_unique_key_record_table.sv =====
// Sorted unique-key record table: a packed, ascending array of key and name records.
// Insert and delete scan for the slot, then shift the later records one at a time;
// search scans to its slot; a dump reads and emits its words one by one. Each result
// word appears in the cycle after it is formed. One item at a time, one entry per
// read-then-act step of the single record memory port pair. Results cannot be stalled.
// Reset (synchronous, active low) empties the table at once; no memory clearing pass.
module sorted_unique_key_record_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [sukrt_pkg::OP_W-1:0]         i_opcode,
    input  logic signed [sukrt_pkg::KEY_W-1:0] i_key,
    input  logic [sukrt_pkg::NAME_W-1:0]       i_record_name,
    output logic                               busy,
    output logic                               o_valid,
    output logic [sukrt_pkg::ST_W-1:0]         o_status,
    output logic signed [sukrt_pkg::KEY_W-1:0] o_out_key,
    output logic [sukrt_pkg::NAME_W-1:0]       o_out_name,
    output logic                               o_last
);

    sukrt_pkg::t_ram_req             ram_req;
    sukrt_pkg::t_result              res;
    logic [sukrt_pkg::REC_W-1:0]     rd_data;

    logic                               r_valid;
    logic [sukrt_pkg::ST_W-1:0]         r_status;
    logic signed [sukrt_pkg::KEY_W-1:0] r_key;
    logic [sukrt_pkg::NAME_BITS-1:0]    r_name;
    logic                               r_last;

    // Each record is stored as one word: key in the upper bits, name below it.
    sukrt_ram #(
        .WIDTH (sukrt_pkg::REC_W),
        .DEPTH (sukrt_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    sukrt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_record_name (i_record_name),
        .i_rd_data     (rd_data),
        .o_busy        (busy),
        .o_ram         (ram_req),
        .o_res         (res)
    );

    // The result register holds each word for exactly one cycle, so the sequencer
    // can return to idle and take the next item while the final word is shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.valid;
        end
        r_status <= res.status;
        r_key    <= res.key;
        r_name   <= res.name;
        r_last   <= res.last;
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_out_key  = r_key;
    assign o_out_name = sukrt_pkg::NAME_W'(r_name);
    assign o_last     = r_last;

endmodule

// ===== rtl/core/sukrt_checker.sv =====
// Port-level checks of the record table, bound to its top level.
module sukrt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic [sukrt_pkg::OP_W-1:0]         i_opcode,
    input logic                               busy,
    input logic                               o_valid,
    input logic [sukrt_pkg::ST_W-1:0]         o_status,
    input logic signed [sukrt_pkg::KEY_W-1:0] o_out_key,
    input logic [sukrt_pkg::NAME_W-1:0]       o_out_name,
    input logic                               o_last
);

    logic op_known;
    assign op_known = (i_opcode <= sukrt_pkg::OP_DUMP_DESC);

    // A known operation either starts work or answers in the very next cycle.
    a_known_op_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && op_known |=> busy || o_valid)
        else $error("known operation produced neither work nor a result");

    // An unused opcode leaves no trace.
    a_unused_op_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !op_known |=> !busy && !o_valid)
        else $error("unused opcode caused activity");

    // A dump word that is not the last one keeps the block busy.
    a_dump_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> busy)
        else $error("dump ended without a last word");

    // Error and empty words carry no record and always close the item.
    a_error_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != sukrt_pkg::ST_OK |->
            o_last && o_out_key == '0 && o_out_name == '0)
        else $error("status word carries record data or is not last");

endmodule

bind sorted_unique_key_record_table sukrt_checker u_sukrt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .i_opcode   (i_opcode),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_status   (o_status),
    .o_out_key  (o_out_key),
    .o_out_name (o_out_name),
    .o_last     (o_last)
);
